// File: rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DQ_DEPTH  = 16;
    localparam int DQ_DATA_W = 32;
    localparam int DQ_CNT_W  = 5;

    localparam logic [DQ_CNT_W-1:0] DQ_CAP_RESET = DQ_CNT_W'(16);

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_dq_action;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_dq_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_LOAD = 2'd2
    } t_dq_fsm;

    typedef struct packed {
        t_dq_action                  action;
        logic signed [DQ_DATA_W-1:0] push_value;
    } t_dq_in;

    typedef struct packed {
        logic signed [DQ_DATA_W-1:0] pop_value;
        t_dq_status                  status;
        logic                        empty_flag;
        logic                        full_flag;
        logic [DQ_CNT_W-1:0]         fill_count;
    } t_dq_out;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic load;
    } t_dq_cmd;

endpackage

// File: rtl/dq_ctrl.sv
`timescale 1ns / 1ps

module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dq_cmd o_cmd
);

    t_dq_fsm r_state;
    t_dq_fsm n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    load_ok;

    // result slot is free, or its word leaves this cycle
    assign load_ok = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (i_in_valid) begin
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                n_state = FSM_LOAD;
            end
            FSM_LOAD: begin
                if (load_ok) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall   = 1'b1;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.load   = 1'b0;
        case (r_state)
            FSM_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            FSM_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            FSM_LOAD: begin
                o_cmd.load = load_ok;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/dq_datapath.sv
`timescale 1ns / 1ps

module dq_datapath
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dq_cmd             i_cmd,
    input  t_dq_in              i_in_word,
    input  logic                i_cfg_wr_en,
    input  logic [DQ_CNT_W-1:0] i_cfg_wr_data,
    output t_dq_out             o_out_word
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = ((IDX_W > DQ_CNT_W) ? IDX_W : DQ_CNT_W) + 1;
    localparam int CNT_MAX = (1 << DQ_CNT_W) - 1;
    localparam logic [DQ_CNT_W-1:0] CAP_CLAMP =
        (DEPTH > CNT_MAX) ? DQ_CNT_W'(CNT_MAX) : DQ_CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(DEPTH);

    logic [DQ_DATA_W-1:0] r_mem [DEPTH];

    logic [DQ_CNT_W-1:0]  r_cap;
    logic [IDX_W-1:0]     r_head;
    logic [DQ_CNT_W-1:0]  r_count;
    t_dq_action           r_action;
    logic [DQ_DATA_W-1:0] r_value;
    t_dq_status           r_status;
    logic [DQ_DATA_W-1:0] r_rd_data;
    t_dq_out              r_out;

    logic [DQ_CNT_W-1:0]  cap_eff;
    logic                 is_push;
    logic                 is_front;
    logic                 at_cap;
    logic                 no_entries;
    logic [IDX_W-1:0]     head_m1;
    logic [IDX_W-1:0]     head_p1;
    logic [SUM_W-1:0]     sum_tail;
    logic [SUM_W-1:0]     sum_last;
    logic [IDX_W-1:0]     tail_idx;
    logic [IDX_W-1:0]     last_idx;
    logic                 wr_en;
    logic                 rd_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    t_dq_status           exec_status;
    t_dq_out              n_out;

    // zero acts as one, anything beyond the store as the store depth
    always_comb begin
        if (r_cap == '0) begin
            cap_eff = DQ_CNT_W'(1);
        end else if (r_cap > CAP_CLAMP) begin
            cap_eff = CAP_CLAMP;
        end else begin
            cap_eff = r_cap;
        end
    end

    assign is_push    = (r_action == ACT_PUSH_FRONT) || (r_action == ACT_PUSH_REAR);
    assign is_front   = (r_action == ACT_PUSH_FRONT) || (r_action == ACT_POP_FRONT);
    assign at_cap     = (r_count >= cap_eff);
    assign no_entries = (r_count == '0);

    assign head_m1 = (r_head == '0) ? IDX_LAST : r_head - IDX_W'(1);
    assign head_p1 = (r_head == IDX_LAST) ? '0 : r_head + IDX_W'(1);

    // head + count stays below twice the depth, so one subtract wraps it
    assign sum_tail = SUM_W'(r_head) + SUM_W'(r_count);
    assign sum_last = sum_tail - SUM_W'(1);
    assign tail_idx = IDX_W'((sum_tail >= SUM_DEPTH) ? sum_tail - SUM_DEPTH : sum_tail);
    assign last_idx = IDX_W'((sum_last >= SUM_DEPTH) ? sum_last - SUM_DEPTH : sum_last);

    always_comb begin
        if (is_push) begin
            exec_status = at_cap ? STAT_OVERFLOW : STAT_OK;
        end else begin
            exec_status = no_entries ? STAT_UNDERFLOW : STAT_OK;
        end
    end

    assign wr_en   = i_cmd.exec && is_push && !at_cap;
    assign rd_en   = i_cmd.exec && !is_push && !no_entries;
    assign wr_addr = is_front ? head_m1 : tail_idx;
    assign rd_addr = is_front ? r_head : last_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= DQ_CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (wr_en) begin
                r_count <= r_count + DQ_CNT_W'(1);
                if (is_front) begin
                    r_head <= head_m1;
                end
            end else if (rd_en) begin
                r_count <= r_count - DQ_CNT_W'(1);
                if (is_front) begin
                    r_head <= head_p1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_in_word.action;
            r_value  <= i_in_word.push_value;
        end
        if (i_cmd.exec) begin
            r_status <= exec_status;
        end
    end

    // count is already updated when the result word is built
    always_comb begin
        if (r_status == STAT_UNDERFLOW) begin
            n_out.pop_value = '1;
        end else if (is_push) begin
            n_out.pop_value = '0;
        end else begin
            n_out.pop_value = r_rd_data;
        end
        n_out.status     = r_status;
        n_out.empty_flag = no_entries;
        n_out.full_flag  = at_cap;
        n_out.fill_count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

endmodule

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// channel   | handshake                | word
// ----------+--------------------------+------------------------------------
// input     | i_in_valid / o_in_stall  | i_in_word  (action, push_value)
// output    | o_out_valid / i_out_stall| o_out_word (pop_value, status,
//           |                          |   empty_flag, full_flag, fill_count)
// config    | i_cfg_wr_en              | i_cfg_wr_data (capacity)
//
// Each word passes through three steps: accept, store access, result load. The store
// has one registered read port, so a pop's data lands in the cycle after its
// address. o_in_stall is high in the store access and result load steps.
// A held result word stalls the next one only in its load cycle.
// Reset is synchronous; the store is not cleared, only control state, pointers, count and capacity.

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_dq_in              i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_dq_out             o_out_word,
    input  logic                i_cfg_wr_en,
    input  logic [DQ_CNT_W-1:0] i_cfg_wr_data
);

    t_dq_cmd cmd;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_word    (o_out_word)
    );

endmodule

// File: rtl/dq_checker.sv
`timescale 1ns / 1ps

module dq_checker
    import dq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_dq_out             o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word taken while one is in flight");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.empty_flag == (o_out_word.fill_count == '0)))
        else $error("empty flag disagrees with fill count");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STAT_UNDERFLOW)
        |-> o_out_word.empty_flag && (o_out_word.pop_value == '1))
        else $error("underflow without empty deque or all-ones word");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STAT_OVERFLOW)
        |-> o_out_word.full_flag && (o_out_word.pop_value == '0))
        else $error("overflow without full deque or zero word");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// File: bench/double_ended_queue_tb.sv
`timescale 1ns / 1ps

// Shadow deque: mirrors the circular store and keeps the words still owed by the block.
class deque_shadow;
    logic [dq_pkg::DQ_DATA_W-1:0] slots [dq_pkg::DQ_DEPTH];
    int unsigned                  head;
    int unsigned                  held;
    logic [dq_pkg::DQ_CNT_W-1:0]  cap_reg;
    dq_pkg::t_dq_out              due_words [$];
    int unsigned                  mismatches;

    function new();
        head       = 0;
        held       = 0;
        cap_reg    = dq_pkg::DQ_CAP_RESET;
        mismatches = 0;
    endfunction

    function void set_capacity(logic [dq_pkg::DQ_CNT_W-1:0] value);
        cap_reg = value;
    endfunction

    // out-of-range settings are clamped to 1..depth
    function int unsigned room_limit();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > dq_pkg::DQ_DEPTH)
            return dq_pkg::DQ_DEPTH;
        return cap_reg;
    endfunction

    function void note_op(dq_pkg::t_dq_in w);
        dq_pkg::t_dq_out r;
        int unsigned     lim;
        lim = room_limit();
        r = '0;
        r.status = dq_pkg::STAT_OK;
        if (w.action == dq_pkg::ACT_PUSH_FRONT || w.action == dq_pkg::ACT_PUSH_REAR) begin
            if (held >= lim) begin
                r.status = dq_pkg::STAT_OVERFLOW;
            end else if (w.action == dq_pkg::ACT_PUSH_FRONT) begin
                head = (head + dq_pkg::DQ_DEPTH - 1) % dq_pkg::DQ_DEPTH;
                slots[head] = w.push_value;
                held++;
            end else begin
                slots[(head + held) % dq_pkg::DQ_DEPTH] = w.push_value;
                held++;
            end
        end else begin
            if (held == 0) begin
                r.status = dq_pkg::STAT_UNDERFLOW;
                r.pop_value = -1;
            end else if (w.action == dq_pkg::ACT_POP_FRONT) begin
                r.pop_value = slots[head];
                head = (head + 1) % dq_pkg::DQ_DEPTH;
                held--;
            end else begin
                r.pop_value = slots[(head + held - 1) % dq_pkg::DQ_DEPTH];
                held--;
            end
        end
        r.empty_flag = (held == 0);
        r.full_flag  = (held >= lim);
        r.fill_count = dq_pkg::DQ_CNT_W'(held);
        due_words.push_back(r);
    endfunction

    function void check_word(dq_pkg::t_dq_out got);
        dq_pkg::t_dq_out exp;
        if (due_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: value %0d status %0d count %0d",
                         got.pop_value, got.status, got.fill_count);
            return;
        end
        exp = due_words.pop_front();
        if (got.pop_value !== exp.pop_value || got.status !== exp.status ||
            got.empty_flag !== exp.empty_flag || got.full_flag !== exp.full_flag ||
            got.fill_count !== exp.fill_count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp value %0d status %0d empty %0b full %0b count %0d",
                         exp.pop_value, exp.status, exp.empty_flag, exp.full_flag,
                         exp.fill_count, "\n          got value %0d status %0d empty %0b",
                         got.pop_value, got.status, got.empty_flag,
                         " full %0b count %0d", got.full_flag, got.fill_count);
        end
    endfunction
endclass

module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned SETTLE      = 6;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    t_dq_in              i_in_word     = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    t_dq_out             o_out_word;
    logic                i_cfg_wr_en   = 1'b0;
    logic [DQ_CNT_W-1:0] i_cfg_wr_data = DQ_CAP_RESET;

    deque_shadow shadow;
    int unsigned cycle_count = 0;
    int unsigned stall_pct   = 0;
    int unsigned hold_reqs   = 0;
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;

    double_ended_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("double_ended_queue_tb: errors");
            $finish;
        end
    end

    // Receiver: checks each word taken, stalls at random, and honours long hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                shadow.check_word(o_out_word);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    function automatic logic [DQ_DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    // valid stays high after acceptance so back-to-back words need no extra edge
    task automatic send_word(t_dq_action act, logic [DQ_DATA_W-1:0] value);
        t_dq_in w;
        w.action     = act;
        w.push_value = value;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (o_in_stall);
        shadow.note_op(w);
    endtask

    task automatic pause_sender(int unsigned n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (shadow.due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [DQ_CNT_W-1:0] value);
        wait_until_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        shadow.set_capacity(value);
    endtask

    task automatic send_random_run(int unsigned n, int unsigned push_pct, int unsigned gap_max);
        int unsigned burst;
        t_dq_action  act;
        burst = $urandom_range(24, 1);
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(99) < push_pct)
                act = $urandom_range(1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_POP_REAR : ACT_POP_FRONT;
            send_word(act, pick_value());
            burst--;
            if (burst == 0) begin
                if (gap_max != 0)
                    pause_sender($urandom_range(gap_max, 1));
                burst = $urandom_range(24, 1);
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pops, extreme words at both ends, then unwind from both ends
        send_word(ACT_POP_FRONT,  32'h0);
        send_word(ACT_POP_REAR,   32'h1234_5678);
        send_word(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        send_word(ACT_PUSH_REAR,  32'h8000_0000);
        send_word(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send_word(ACT_PUSH_REAR,  32'h0000_0000);
        send_word(ACT_PUSH_FRONT, 32'h5555_5555);
        send_word(ACT_PUSH_REAR,  32'hAAAA_AAAA);
        send_word(ACT_POP_FRONT,  32'hFFFF_FFFF);
        send_word(ACT_POP_REAR,   32'h0);
        send_word(ACT_POP_REAR,   32'h0);
        send_word(ACT_POP_FRONT,  32'h0);
        send_word(ACT_POP_FRONT,  32'h0);
        send_word(ACT_POP_REAR,   32'h0);
        send_word(ACT_POP_FRONT,  32'h0);

        // zero capacity behaves as one entry
        write_capacity(5'd0);
        send_word(ACT_PUSH_FRONT, 32'hDEAD_BEEF);
        send_word(ACT_PUSH_REAR,  32'h0BAD_F00D);
        send_word(ACT_POP_REAR,   32'h0);
        send_word(ACT_POP_REAR,   32'h0);

        write_capacity(5'd16);
        stall_pct = 30;
        send_random_run(200, 65, 6);

        // make sure plenty is held, then shrink the capacity beneath the count
        while (shadow.held < 12)
            send_word(ACT_PUSH_FRONT, pick_value());
        write_capacity(5'd3);
        stall_pct = 20;
        send_random_run(80, 45, 4);

        // over-range capacity, and a long receiver hold-off to back the block up
        write_capacity(5'd31);
        stall_pct = 0;
        hold_reqs++;
        send_random_run(150, 55, 0);

        write_capacity(5'd1);
        stall_pct = 40;
        send_random_run(80, 50, 3);

        write_capacity(5'd2);
        stall_pct = 10;
        send_random_run(60, 50, 8);

        for (int r = 0; r < 4; r++) begin
            write_capacity(DQ_CNT_W'($urandom_range(31)));
            stall_pct = $urandom_range(60);
            send_random_run(60, $urandom_range(70, 30), $urandom_range(8));
        end

        write_capacity(5'd16);
        stall_pct = 0;
        send_random_run(150, 50, 0);
        stall_pct = 25;
        send_random_run(80, 25, 2);

        wait_until_idle();
        if (shadow.mismatches == 0 && shadow.due_words.size() == 0)
            $display("double_ended_queue_tb: clean");
        else
            $display("double_ended_queue_tb: errors");
        $finish;
    end
endmodule
